/* rtl/core/relative_path_normalizer_top_macros.svh */
// assertion macros for the relative path normalizer
// expects clk and rst_n in the scope of the module that uses them

`ifndef RELATIVE_PATH_NORMALIZER_TOP_MACROS_SVH
`define RELATIVE_PATH_NORMALIZER_TOP_MACROS_SVH

// checked on every edge outside reset
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RPN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rpn_pkg.sv */
// shared types and constants of the relative path normalizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

  localparam int OUT_SIZE  = 64;
  localparam int SEG_DEPTH = 32;
  localparam int CH_W      = 8;
  localparam int CAP_W     = 7;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 6;
  localparam int POS_W     = 8;
  localparam int ST_AW     = $clog2(OUT_SIZE);
  localparam int SEG_AW    = $clog2(SEG_DEPTH);

  localparam logic [CH_W-1:0]  CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0]  CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0]  CH_NUL    = 8'h00;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(OUT_SIZE);
  localparam logic [LEN_W-1:0] LEN_MAX   = '1;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_ONE,
    DP_TWO,
    DP_OTHER
  } dot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_END,
    ST_POP,
    ST_FIN,
    ST_RD,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic take_char;
    logic term_latch;
    logic seg_eval;
    logic pop_apply;
    logic single_load;
    logic emit_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic is_term;
    logic term_nul;
    logic seg_pop;
    logic single;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/rpn_if.sv */
// valid/ready channel interfaces for input characters and result words
// depends on rpn_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rpn_in_if;
  import rpn_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface rpn_out_if;
  import rpn_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_char;
  logic            ok;
  logic            last;

  modport source (output valid, output out_char, output ok, output last, input ready);
  modport sink (input valid, input out_char, input ok, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/relative_path_normalizer_top.sv */
// top level of the relative path normalizer
// depends on rpn_pkg, rpn_if, rpn_ctrl and rpn_datapath
//
// in_chan takes one path character per word; a 0 character ends the path.
// out_chan returns the normalized path one character per word with ok set,
// last marking the final word; an empty path gives "." and a failed path a
// single word {0, ok 0, last 1}. cfg_we/cfg_wdata write the output capacity
// (reset value 64), to be changed only between paths.
// A plain character is taken in the idle state. A slash passes through the
// segment evaluation state, and the pop state when it closes a ".." segment
// (one read of the segment start stack). A terminator adds the finish state,
// then a path store read and an output register load per output character.
// Reset clears the path state and the output valid flag and restores the
// capacity; store contents are left as they are and never read unwritten.
// When out_chan stalls, the sequencer holds its place and stops taking new
// characters until the output register frees; the last word of a path may
// still wait in the register while the next path starts.
`timescale 1ns / 1ps
`default_nettype none

module relative_path_normalizer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rpn_pkg::CAP_W-1:0] cfg_wdata,
  rpn_in_if.sink                    in_chan,
  rpn_out_if.source                 out_chan
);
  import rpn_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  rpn_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_chan.ch),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_char  (out_chan.out_char),
    .out_ok    (out_chan.ok),
    .out_last  (out_chan.last)
  );

  assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

/* rtl/core/rpn_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rpn_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/rpn_ctrl.sv */
// sequencer of the relative path normalizer
// depends on rpn_pkg; drives commands into rpn_datapath
`timescale 1ns / 1ps
`default_nettype none

module rpn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpn_pkg::sts_t sts_i,
  output rpn_pkg::cmd_t cmd_o
);
  import rpn_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts_i.is_term) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (sts_i.seg_pop) begin
          state_nxt = ST_POP;
        end else if (sts_i.term_nul) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        state_nxt = sts_i.term_nul ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (!sts_i.single) begin
          state_nxt = ST_RD;
        end else if (sts_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          state_nxt = sts_i.emit_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.take_char  = !sts_i.is_term;
          cmd_o.term_latch = sts_i.is_term;
        end
      end
      ST_END: begin
        cmd_o.seg_eval = 1'b1;
      end
      ST_POP: begin
        cmd_o.pop_apply = 1'b1;
      end
      ST_FIN: begin
        if (sts_i.single && sts_i.out_free) begin
          cmd_o.single_load = 1'b1;
          cmd_o.clear       = 1'b1;
        end
      end
      ST_RD: begin
        cmd_o = '0;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.clear     = sts_i.emit_last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rpn_datapath.sv */
// path state, segment stack, stores and output register of the normalizer
// depends on rpn_pkg, rpn_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "relative_path_normalizer_top_macros.svh"

module rpn_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rpn_pkg::CAP_W-1:0] cfg_wdata,
  input  logic [rpn_pkg::CH_W-1:0]  in_ch,
  input  rpn_pkg::cmd_t             cmd_i,
  output rpn_pkg::sts_t             sts_o,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [rpn_pkg::CH_W-1:0]  out_char,
  output logic                      out_ok,
  output logic                      out_last
);
  import rpn_pkg::*;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [LEN_W-1:0] kept_r, kept_nxt;
  logic [CNT_W-1:0] seg_cnt_r, seg_cnt_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  dot_t             dp_r, dp_nxt;
  logic             failed_r, failed_nxt;
  logic             nul_r, nul_nxt;
  logic [ST_AW-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]  out_char_r, out_char_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic             out_last_r, out_last_nxt;

  logic [CAP_W-1:0] eff_cap;
  logic             sep;
  logic [POS_W-1:0] char_pos;
  logic [POS_W-1:0] need;
  logic [LEN_W-1:0] seg_start;
  logic [CNT_W-1:0] seg_top;
  logic             seg_empty, seg_dot1, seg_dot2, seg_fits, do_append;
  logic             fin_fail, emit_last, out_free;

  logic             st_we;
  logic [ST_AW-1:0] st_waddr;
  logic [CH_W-1:0]  st_wdata;
  logic [CH_W-1:0]  st_rdata;
  logic [LEN_W-1:0] seg_rdata;

  assign eff_cap   = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign sep       = (kept_r != '0);
  assign char_pos  = POS_W'(kept_r) + POS_W'(sep) + POS_W'(cur_len_r);
  assign need      = char_pos + POS_W'(1);
  assign seg_start = kept_r + LEN_W'(sep);
  assign seg_top   = seg_cnt_r - CNT_W'(1);

  assign seg_empty = (cur_len_r == '0) || failed_r;
  assign seg_dot1  = (cur_len_r == LEN_W'(1)) && (dp_r == DP_ONE);
  assign seg_dot2  = (cur_len_r == LEN_W'(2)) && (dp_r == DP_TWO);
  assign seg_fits  = (need <= POS_W'(eff_cap)) && (seg_cnt_r < CNT_W'(SEG_DEPTH));
  assign do_append = cmd_i.seg_eval && !seg_empty && !seg_dot1 && !seg_dot2 && seg_fits;

  assign fin_fail  = failed_r || (eff_cap == '0) || ((kept_r == '0) && (eff_cap < CAP_W'(2)));
  assign emit_last = ((LEN_W'(idx_r) + LEN_W'(1)) == kept_r);
  assign out_free  = !out_valid_r || out_ready;

  assign sts_o.is_term   = (in_ch == CH_SLASH) || (in_ch == CH_NUL);
  assign sts_o.term_nul  = nul_r;
  assign sts_o.seg_pop   = !failed_r && seg_dot2 && (seg_cnt_r != '0);
  assign sts_o.single    = fin_fail || (kept_r == '0);
  assign sts_o.out_free  = out_free;
  assign sts_o.emit_last = emit_last;

  // path text store
  assign st_we = (cmd_i.take_char && !failed_r && (char_pos < POS_W'(OUT_SIZE)))
               || (do_append && sep && (kept_r < LEN_W'(OUT_SIZE)));
  assign st_waddr = cmd_i.take_char ? char_pos[ST_AW-1:0] : kept_r[ST_AW-1:0];
  assign st_wdata = cmd_i.take_char ? in_ch : CH_SLASH;

  rpn_ram #(
    .W     (CH_W),
    .DEPTH (OUT_SIZE)
  ) u_path_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (idx_r),
    .rdata (st_rdata)
  );

  // segment start stack
  rpn_ram #(
    .W     (LEN_W),
    .DEPTH (SEG_DEPTH)
  ) u_seg_starts (
    .clk   (clk),
    .we    (do_append),
    .waddr (seg_cnt_r[SEG_AW-1:0]),
    .wdata (seg_start),
    .raddr (seg_top[SEG_AW-1:0]),
    .rdata (seg_rdata)
  );

  always_comb begin
    cap_nxt     = cap_r;
    kept_nxt    = kept_r;
    seg_cnt_nxt = seg_cnt_r;
    cur_len_nxt = cur_len_r;
    dp_nxt      = dp_r;
    failed_nxt  = failed_r;
    nul_nxt     = nul_r;
    idx_nxt     = idx_r;

    if (cfg_we) begin
      cap_nxt = cfg_wdata;
    end

    if (cmd_i.take_char && !failed_r) begin
      if (cur_len_r != LEN_MAX) begin
        cur_len_nxt = cur_len_r + LEN_W'(1);
      end
      if (in_ch == CH_DOT) begin
        case (dp_r)
          DP_NONE: dp_nxt = DP_ONE;
          DP_ONE:  dp_nxt = DP_TWO;
          default: dp_nxt = DP_OTHER;
        endcase
      end else begin
        dp_nxt = DP_OTHER;
      end
    end

    if (cmd_i.term_latch) begin
      nul_nxt = (in_ch == CH_NUL);
    end

    if (cmd_i.seg_eval) begin
      cur_len_nxt = '0;
      dp_nxt      = DP_NONE;
      if (!seg_empty && !seg_dot1) begin
        if (seg_dot2) begin
          if (seg_cnt_r == '0) begin
            failed_nxt = 1'b1;
          end else begin
            seg_cnt_nxt = seg_top;
          end
        end else if (!seg_fits) begin
          failed_nxt = 1'b1;
        end else begin
          seg_cnt_nxt = seg_cnt_r + CNT_W'(1);
          kept_nxt    = seg_start + cur_len_r;
        end
      end
    end

    if (cmd_i.pop_apply) begin
      kept_nxt = (seg_rdata != '0) ? seg_rdata - LEN_W'(1) : '0;
    end

    if (cmd_i.emit_load) begin
      idx_nxt = idx_r + ST_AW'(1);
    end

    if (cmd_i.clear) begin
      kept_nxt    = '0;
      seg_cnt_nxt = '0;
      cur_len_nxt = '0;
      dp_nxt      = DP_NONE;
      failed_nxt  = 1'b0;
      nul_nxt     = 1'b0;
      idx_nxt     = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_ok_nxt    = out_ok_r;
    out_last_nxt  = out_last_r;
    if (cmd_i.single_load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = fin_fail ? CH_NUL : CH_DOT;
      out_ok_nxt    = !fin_fail;
      out_last_nxt  = 1'b1;
    end else if (cmd_i.emit_load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = st_rdata;
      out_ok_nxt    = 1'b1;
      out_last_nxt  = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      kept_r      <= '0;
      seg_cnt_r   <= '0;
      cur_len_r   <= '0;
      dp_r        <= DP_NONE;
      failed_r    <= 1'b0;
      nul_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      kept_r      <= kept_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
      cur_len_r   <= cur_len_nxt;
      dp_r        <= dp_nxt;
      failed_r    <= failed_nxt;
      nul_r       <= nul_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_ok    = out_ok_r;
  assign out_last  = out_last_r;

  `RPN_ASSERT(a_clear_empties, cmd_i.clear |=> (kept_r == '0 && seg_cnt_r == '0 && !failed_r), "path state not cleared after final word")
  `RPN_ASSERT(a_load_when_free, (cmd_i.single_load || cmd_i.emit_load) |-> out_free, "result loaded over a word not yet taken")
  `RPN_ASSERT(a_pop_follows_eval, cmd_i.pop_apply |-> $past(cmd_i.seg_eval), "segment pop applied without a stack read")

endmodule

`default_nettype wire
